// ----- src/ucs_pkg.sv -----
// ----------------------------------------------------------------------------
// ucs_pkg: shared types and constants of the UDP checksum block
// Operation format that travels from the front end to the accumulator,
// queue status, item codes and default sizes.
// ----------------------------------------------------------------------------
package ucs_pkg;

   // item codes of the action field
   localparam logic ACTION_HEADER  = 1'b0;
   localparam logic ACTION_PAYLOAD = 1'b1;

   // a header adds nine 16-bit words: the sum fits in 20 bits
   localparam int HDR_SUM_W = 20;
   localparam int WORD_W    = 16;
   localparam int SUM_W     = 32;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // one accumulator operation
   typedef struct packed {
      logic                 load;   // replace the sum instead of adding
      logic                 last;   // close the packet, emit a checksum
      logic [HDR_SUM_W-1:0] value;
   } ucs_op_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } ucs_q_stat_type;

endpackage

// ----- src/ucs_front.sv -----
// ----------------------------------------------------------------------------
// ucs_front: item classification
// Turns each accepted item into at most one accumulator operation: a header
// becomes a load of its pseudo-header sum, payload bytes pair into words.
// ----------------------------------------------------------------------------
module ucs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    action,
   input  logic [31:0]             source_address,
   input  logic [31:0]             dest_address,
   input  logic [7:0]              protocol_number,
   input  logic [15:0]             udp_length,
   input  logic [15:0]             source_port,
   input  logic [15:0]             dest_port,
   input  logic [7:0]              data_byte,
   input  logic                    last,
   output logic                    push,
   output ucs_pkg::ucs_op_type     push_op
);
   import ucs_pkg::*;

   logic                 pending_ff, pending_in;
   logic [7:0]           held_ff, held_in;
   logic                 need_op;
   logic [HDR_SUM_W-1:0] hdr_sum;

   // pseudo-header plus UDP header, checksum word counted as zero
   assign hdr_sum = HDR_SUM_W'(source_address[31:16]) + HDR_SUM_W'(source_address[15:0])
                  + HDR_SUM_W'(dest_address[31:16])   + HDR_SUM_W'(dest_address[15:0])
                  + HDR_SUM_W'(protocol_number)       + HDR_SUM_W'(udp_length)
                  + HDR_SUM_W'(source_port)           + HDR_SUM_W'(dest_port)
                  + HDR_SUM_W'(udp_length);

   always_comb begin
      need_op       = 1'b1;
      pending_in    = pending_ff;
      held_in       = held_ff;
      push_op.load  = 1'b0;
      push_op.last  = last;
      push_op.value = '0;
      case (action)
         ACTION_HEADER: begin
            push_op.load  = 1'b1;
            push_op.value = hdr_sum;
            pending_in    = 1'b0;
         end
         ACTION_PAYLOAD: begin
            if (pending_ff) begin
               push_op.value = HDR_SUM_W'({held_ff, data_byte});
               pending_in    = 1'b0;
            end else if (last) begin
               // odd final byte: pad the low half with zero
               push_op.value = HDR_SUM_W'({data_byte, 8'h00});
            end else begin
               need_op    = 1'b0;
               pending_in = 1'b1;
               held_in    = data_byte;
            end
         end
         default: begin
            need_op = 1'b0;
         end
      endcase
      if (last) begin
         pending_in = 1'b0;
      end
   end

   assign push = accept & need_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- src/ucs_queue.sv -----
// ----------------------------------------------------------------------------
// ucs_queue: operation queue
// Small first-in first-out buffer that decouples the front end from the
// accumulator.
// ----------------------------------------------------------------------------
module ucs_queue #(
   parameter int DEPTH = ucs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ucs_pkg::ucs_op_type     push_op,
   input  logic                    pop,
   output ucs_pkg::ucs_op_type     head_op,
   output ucs_pkg::ucs_q_stat_type stat
);
   import ucs_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ucs_op_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign head_op        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!stat.full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.not_empty)
      else $error("queue read while empty");
`endif

endmodule

// ----- src/ucs_back.sv -----
// ----------------------------------------------------------------------------
// ucs_back: accumulator and result stage
// Runs the end-around-carry sum, then folds and inverts it into the
// output register.
// ----------------------------------------------------------------------------
module ucs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ucs_pkg::ucs_q_stat_type q_stat,
   input  ucs_pkg::ucs_op_type     head_op,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [15:0]             rsp_checksum_value
);
   import ucs_pkg::*;

   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  sum_ff;
   logic              sum_vld_ff, sum_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_checksum_ff;
   logic              out_free, mid_free;
   logic [SUM_W-1:0]  base;
   logic [SUM_W:0]    wide;
   logic [SUM_W-1:0]  new_sum;
   logic [WORD_W:0]   fold1, fold2;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mid_free = !sum_vld_ff || out_free;
   assign pop      = q_stat.not_empty && mid_free;

   // add with end-around carry; cannot carry twice
   assign base    = head_op.load ? '0 : acc_ff;
   assign wide    = {1'b0, base} + (SUM_W + 1)'(head_op.value);
   assign new_sum = wide[SUM_W-1:0] + SUM_W'(wide[SUM_W]);

   assign fold1 = (WORD_W + 1)'(sum_ff[31:16]) + (WORD_W + 1)'(sum_ff[15:0]);
   assign fold2 = fold1 + (WORD_W + 1)'(fold1[WORD_W]);

   always_comb begin
      acc_in       = acc_ff;
      sum_vld_in   = sum_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = sum_vld_ff;
      end
      if (mid_free) begin
         sum_vld_in = pop && head_op.last;
      end
      if (pop) begin
         acc_in = head_op.last ? '0 : new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         sum_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         sum_vld_ff   <= sum_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_op.last) begin
         sum_ff <= new_sum;
      end
      if (out_free && sum_vld_ff) begin
         rsp_checksum_ff <= ~fold2[WORD_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_checksum_value = rsp_checksum_ff;

`ifndef SYNTH
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && head_op.last) |=> (acc_ff == '0))
      else $error("sum not cleared after closing a packet");

   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sum_vld_ff))
      else $error("result raised without a closed sum");

   a_sum_held: assert property (@(posedge clock) disable iff (reset)
      (sum_vld_ff && !out_free) |=> (sum_vld_ff && $stable(sum_ff)))
      else $error("closed sum lost while output stalled");
`endif

endmodule

// ----- src/udp_checksum_with_pseudo_header.sv -----
// ----------------------------------------------------------------------------
// udp_checksum_with_pseudo_header: IPv4 UDP checksum engine
// Header beats load the pseudo-header and UDP header sum, payload beats add
// bytes paired into network-order words, and the last beat of a packet
// yields the inverted folded ones' complement sum.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  action, addresses, ports, byte, last
//   rsp_      out         rsp_valid / rsp_stall  checksum_value
//
// - One beat per cycle, sustained, with no output stall. A closing beat's checksum
//   passes the operation queue, the closed-sum register and the output register.
//   The accumulator sets the pace: one 32-bit add with end-around carry per cycle.
// - Synchronous active-high reset clears the sum, the pending byte, the
//   queue and the result stage.
// - req_stall rises only when the operation queue is full; the accumulator
//   stops only while a closed sum waits behind a stalled output register.
// ----------------------------------------------------------------------------
module udp_checksum_with_pseudo_header #(
   parameter int QUEUE_DEPTH = ucs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [7:0]  req_protocol_number,
   input  logic [15:0] req_udp_length,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_checksum_value
);
   import ucs_pkg::*;

   ucs_op_type     push_op, head_op;
   ucs_q_stat_type q_stat;
   logic           accept, push, pop;

   // hold the request side only while the queue has no room
   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;

   // classify the beat and pair payload bytes
   ucs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .action          (req_action),
      .source_address  (req_source_address),
      .dest_address    (req_dest_address),
      .protocol_number (req_protocol_number),
      .udp_length      (req_udp_length),
      .source_port     (req_source_port),
      .dest_port       (req_dest_port),
      .data_byte       (req_data_byte),
      .last            (req_last),
      .push            (push),
      .push_op         (push_op)
   );

   // buffer operations between the two halves
   ucs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .stat    (q_stat)
   );

   // accumulate, fold and drive the result
   ucs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_stat             (q_stat),
      .head_op            (head_op),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_checksum_value (rsp_checksum_value)
   );

endmodule
